// ===== hw/rtl/mbe_pkg.sv =====
// mbe_pkg: shared constants of the escape-time core
// no dependencies; used by mbe_mul, mandelbrot_escape_time_core and the testbench
package mbe_pkg;

  // default fraction bits of the Q8.F datapath
  localparam int FRAC_BITS_DEF = 28;

  // default width of the iteration counter
  localparam int COUNT_BITS_DEF = 16;

  // register map
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int LIMIT_W = 16;
  localparam logic [LIMIT_W-1:0] MAX_ITER_RESET = 16'd255;

  // width of the operands of the shared multiplier for a given fraction width
  function automatic int mul_width(input int frac_bits);
    return frac_bits + 2;
  endfunction

endpackage

// ===== hw/rtl/mandelbrot_escape_time_core.sv =====
// mandelbrot_escape_time_core: escape-time iteration of one point c
// depends on mbe_pkg and mbe_mul (the one multiplier shared by all products)
//
// Usage:
//   An item (in_c_real, in_c_imag, signed Q4.F) is taken at a rising edge with
//   start high and busy low. z starts at 0 and z = z*z + c repeats while
//   |z|^2 < 4 and the count is below max_iterations. busy stays high until the
//   result is shown.
//   The result (out_iteration_count, out_reached_limit) is on the output ports
//   for exactly one cycle with out_valid high; the receiver has no way to stall.
//   Each iteration steps through S_CHK, S_SQR, S_SQI and S_CRS: three products
//   go one after another through the single registered multiplier, then z and
//   the count update. An item leaves from S_CHK on the limit test or on a
//   component at 2.0 or beyond, or from S_SQI on the |z|^2 test; the next item
//   can be taken while the result strobe is shown.
//   max_iterations is written over the APB port at any byte address (reset 255)
//   and must only change while busy is low. A limit of 0 gives count 0 with
//   out_reached_limit set.
//   Reset (rst_n low, synchronous) drops any item in flight, clears busy and
//   out_valid and restores max_iterations to 255.
module mandelbrot_escape_time_core #(
  parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = mbe_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // item input
  input  logic                            start,
  output logic                            busy,
  input  logic signed [31:0]              in_c_real,
  input  logic signed [31:0]              in_c_imag,
  // result
  output logic                            out_valid,
  output logic [15:0]                     out_iteration_count,
  output logic                            out_reached_limit,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mbe_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mbe_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int ZW  = FRAC_BITS + 8;               // Q8.F values
  localparam int NW  = ZW + 1;                      // sums before clamping
  localparam int W   = mbe_pkg::mul_width(FRAC_BITS);
  localparam int PW  = 2 * W;
  localparam int SQW = FRAC_BITS + 3;               // truncated square
  localparam int XW  = FRAC_BITS + 4;               // truncated 2*zr*zi
  localparam int CW  = (ZW > 32) ? ZW : 32;         // input before clamping
  localparam int MW  = (COUNT_BITS > mbe_pkg::LIMIT_W) ? COUNT_BITS : mbe_pkg::LIMIT_W;
  localparam int LW  = mbe_pkg::LIMIT_W;

  localparam logic signed [NW-1:0] ZMAX_N = (NW'(1) <<< (ZW - 1)) - NW'(1);
  localparam logic signed [NW-1:0] ZMIN_N = -ZMAX_N - NW'(1);
  localparam logic signed [CW-1:0] ZMAX_C = CW'(ZMAX_N);
  localparam logic signed [CW-1:0] ZMIN_C = CW'(ZMIN_N);
  localparam logic signed [ZW-1:0] TWO_Q  = ZW'(2) <<< FRAC_BITS;
  localparam logic signed [ZW-1:0] NTWO_Q = -TWO_Q;
  localparam logic signed [SQW:0]  FOUR_Q = (SQW + 1)'(4) <<< FRAC_BITS;
  localparam logic [COUNT_BITS-1:0] CMAX  = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,    // limit and magnitude tests, zr*zr into the multiplier
    S_SQR,    // take zr^2, zi*zi into the multiplier
    S_SQI,    // take zi^2, escape test, new zr, zr*zi into the multiplier
    S_CRS     // take 2*zr*zi, new zi, count up
  } state_t;

  state_t                   state_r, state_nxt;
  logic signed [ZW-1:0]     cr_r, cr_nxt;
  logic signed [ZW-1:0]     ci_r, ci_nxt;
  logic signed [ZW-1:0]     zr_r, zr_nxt;
  logic signed [ZW-1:0]     zi_r, zi_nxt;
  logic signed [ZW-1:0]     nr_r, nr_nxt;
  logic signed [SQW-1:0]    sr_r, sr_nxt;
  logic [COUNT_BITS-1:0]    n_r, n_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [15:0]              out_count_r, out_count_nxt;
  logic                     out_lim_r, out_lim_nxt;
  logic [LW-1:0]            max_iter_r;

  logic signed [W-1:0]      mul_a, mul_b;
  logic signed [PW-1:0]     prod_r;
  logic signed [SQW-1:0]    sq_w;
  logic signed [XW-1:0]     cross_w;
  logic signed [SQW:0]      mag2_w;
  logic signed [NW-1:0]     nr_full, ni_full;
  logic signed [CW-1:0]     cr_ext, ci_ext;
  logic [COUNT_BITS-1:0]    limit_w;
  logic [MW-1:0]            n_ext;
  logic                     big_w, accept_w, cfg_wr;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = mbe_pkg::CFG_DATA_W'(max_iter_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= mbe_pkg::MAX_ITER_RESET;
    end else if (cfg_wr && (paddr >> 2) == '0) begin
      max_iter_r <= pwdata[LW-1:0];
    end
  end

  // limit saturated to the counter range
  always_comb begin
    if (MW'(max_iter_r) > MW'(CMAX)) begin
      limit_w = CMAX;
    end else begin
      limit_w = COUNT_BITS'(max_iter_r);
    end
  end

  // input point clamped into the Q8 range
  assign cr_ext = CW'(in_c_real);
  assign ci_ext = CW'(in_c_imag);

  always_comb begin
    if (cr_ext > ZMAX_C) begin
      cr_nxt = ZW'(ZMAX_C);
    end else if (cr_ext < ZMIN_C) begin
      cr_nxt = ZW'(ZMIN_C);
    end else begin
      cr_nxt = ZW'(cr_ext);
    end
    if (ci_ext > ZMAX_C) begin
      ci_nxt = ZW'(ZMAX_C);
    end else if (ci_ext < ZMIN_C) begin
      ci_nxt = ZW'(ZMIN_C);
    end else begin
      ci_nxt = ZW'(ci_ext);
    end
  end

  // operand select of the shared multiplier
  always_comb begin
    case (state_r)
      S_SQR: begin
        mul_a = zi_r[W-1:0];
        mul_b = zi_r[W-1:0];
      end
      S_SQI: begin
        mul_a = zr_r[W-1:0];
        mul_b = zi_r[W-1:0];
      end
      default: begin
        mul_a = zr_r[W-1:0];
        mul_b = zr_r[W-1:0];
      end
    endcase
  end

  mbe_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  // truncated products (arithmetic shift is floor)
  assign sq_w    = prod_r[FRAC_BITS+SQW-1:FRAC_BITS];
  assign cross_w = prod_r[FRAC_BITS-1+XW-1:FRAC_BITS-1];
  assign mag2_w  = (SQW + 1)'(sr_r) + (SQW + 1)'(sq_w);
  assign nr_full = NW'(sr_r) - NW'(sq_w) + NW'(cr_r);
  assign ni_full = NW'(cross_w) + NW'(ci_r);

  // components at or beyond 2.0 escape without squaring
  assign big_w = (zr_r >= TWO_Q) || (zr_r <= NTWO_Q) ||
                 (zi_r >= TWO_Q) || (zi_r <= NTWO_Q);

  assign accept_w = start && (state_r == S_IDLE);
  assign n_ext    = MW'(n_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    nr_nxt        = nr_r;
    sr_nxt        = sr_r;
    n_nxt         = n_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    out_lim_nxt   = out_lim_r;
    case (state_r)
      S_IDLE: begin
        if (accept_w) begin
          zr_nxt    = '0;
          zi_nxt    = '0;
          n_nxt     = '0;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (n_r == limit_w || big_w) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = n_ext[15:0];
          out_lim_nxt   = (n_r == limit_w);
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        sr_nxt    = sq_w;
        state_nxt = S_SQI;
      end
      S_SQI: begin
        if (mag2_w >= FOUR_Q) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = n_ext[15:0];
          out_lim_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          if (nr_full > ZMAX_N) begin
            nr_nxt = ZW'(ZMAX_N);
          end else if (nr_full < ZMIN_N) begin
            nr_nxt = ZW'(ZMIN_N);
          end else begin
            nr_nxt = ZW'(nr_full);
          end
          state_nxt = S_CRS;
        end
      end
      S_CRS: begin
        zr_nxt = nr_r;
        if (ni_full > ZMAX_N) begin
          zi_nxt = ZW'(ZMAX_N);
        end else if (ni_full < ZMIN_N) begin
          zi_nxt = ZW'(ZMIN_N);
        end else begin
          zi_nxt = ZW'(ni_full);
        end
        n_nxt     = n_r + COUNT_BITS'(1);
        state_nxt = S_CHK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    zr_r        <= zr_nxt;
    zi_r        <= zi_nxt;
    nr_r        <= nr_nxt;
    sr_r        <= sr_nxt;
    n_r         <= n_nxt;
    out_count_r <= out_count_nxt;
    out_lim_r   <= out_lim_nxt;
    if (accept_w) begin
      cr_r <= cr_nxt;
      ci_r <= ci_nxt;
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;
  assign out_reached_limit   = out_lim_r;

endmodule

// ===== hw/rtl/mbe_mul.sv =====
// mbe_mul: shared signed multiplier with registered product
// depends on mbe_pkg for the default operand width
module mbe_mul #(
  parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF,
  localparam int W = mbe_pkg::mul_width(FRAC_BITS)
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   op_a,
  input  logic signed [W-1:0]   op_b,
  output logic signed [2*W-1:0] prod_r
);

  logic signed [2*W-1:0] prod_nxt;

  // full precision product, registered once
  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== sim/mandelbrot_escape_time_core_tb.sv =====
// mandelbrot_escape_time_core_tb: self-checking bench for the escape-time core
// predicts count and limit flag per point with a fixed-point model of its own
// depends on mbe_pkg and mandelbrot_escape_time_core
module mandelbrot_escape_time_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = mbe_pkg::FRAC_BITS_DEF;
  localparam int ZW = FRAC + 8;
  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int MAX_REPORTS = 40;
  localparam logic [mbe_pkg::CFG_ADDR_W-1:0] MAX_ITER_ADDR = '0;

  // double-width signed values hold exact products of Q8.F operands
  typedef logic signed [2*ZW-1:0] wide_t;
  localparam wide_t Q_MAX = (wide_t'(1) <<< (FRAC + 7)) - wide_t'(1);
  localparam wide_t Q_MIN = -Q_MAX - wide_t'(1);
  localparam wide_t TWO = wide_t'(2) <<< FRAC;
  localparam wide_t FOUR = wide_t'(4) <<< FRAC;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic drain;
  } point_t;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [15:0] count;
    logic at_limit;
  } escape_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic signed [31:0] in_c_real = '0;
  logic signed [31:0] in_c_imag = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [mbe_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [mbe_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [mbe_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;
  logic busy;
  logic out_valid;
  logic [15:0] out_iteration_count;
  logic out_reached_limit;

  point_t pending_points[$];
  escape_t predicted_escapes[$];
  logic [15:0] max_iter_q = mbe_pkg::MAX_ITER_RESET;
  int idle_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  mandelbrot_escape_time_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_c_real           (in_c_real),
    .in_c_imag           (in_c_imag),
    .out_valid           (out_valid),
    .out_iteration_count (out_iteration_count),
    .out_reached_limit   (out_reached_limit),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // clamp to the Q8.F range
  function automatic wide_t sat_q(input wide_t v);
    if (v > Q_MAX) begin
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      return Q_MIN;
    end
    return v;
  endfunction

  // iterate z = z*z + c from zero, floor-truncated products
  function automatic escape_t predict_escape(input logic signed [31:0] c_re,
                                             input logic signed [31:0] c_im,
                                             input logic [15:0] limit);
    wide_t cr, ci, zr, zi, sr, si, nr, ni;
    int unsigned n;
    logic escaped;
    escape_t r;
    cr = sat_q(wide_t'(c_re));
    ci = sat_q(wide_t'(c_im));
    zr = '0;
    zi = '0;
    n = 0;
    escaped = 1'b0;
    while (!escaped && n < limit) begin
      // a component at 2.0 or beyond has escaped already
      if (zr >= TWO || zr <= -TWO || zi >= TWO || zi <= -TWO) begin
        escaped = 1'b1;
      end else begin
        sr = (zr * zr) >>> FRAC;
        si = (zi * zi) >>> FRAC;
        if (sr + si >= FOUR) begin
          escaped = 1'b1;
        end else begin
          nr = sat_q(sr - si + cr);
          ni = sat_q(((zr * zi) >>> (FRAC - 1)) + ci);
          zr = nr;
          zi = ni;
          n++;
        end
      end
    end
    r.re = c_re;
    r.im = c_im;
    r.count = n[15:0];
    r.at_limit = (n == limit);
    return r;
  endfunction

  // mostly points near the set, some deep in a valley, some anywhere
  function automatic point_t rand_point();
    point_t p;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      p.re = $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
      p.im = $signed($urandom_range(0, 32'h3000_0000)) - 32'sh1800_0000;
    end else if (pick < 80) begin
      p.re = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0D00_0000;
      p.im = $signed($urandom_range(0, 32'h0400_0000));
      if ($urandom_range(0, 1) == 1) begin
        p.im = -p.im;
      end
    end else begin
      p.re = $urandom;
      p.im = $urandom;
    end
    p.drain = ($urandom_range(0, 99) < 2);
    return p;
  endfunction

  // real part forced to magnitude 4.0 or more, so it leaves after the first iteration
  function automatic point_t escape_point();
    point_t p;
    p.re = $urandom;
    p.im = $urandom;
    p.re[30] = ~p.re[31];
    p.drain = 1'b0;
    return p;
  endfunction

  task automatic push_point(input logic signed [31:0] re, input logic signed [31:0] im,
                            input logic drain);
    point_t p;
    p.re = re;
    p.im = im;
    p.drain = drain;
    pending_points = {pending_points, p};
  endtask

  // one register access, setup then access phase
  task automatic apb_access(input logic wr, input logic [31:0] data,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= MAX_ITER_ADDR;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_limit_reg(input logic [15:0] want);
    logic [31:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd[15:0] !== want) begin
      report_mismatch($sformatf("max_iterations reads %0h, want %0h", rd[15:0], want));
    end
  endtask

  task automatic write_limit(input logic [15:0] lim);
    logic [31:0] rd;
    apb_access(1'b1, {16'($urandom), lim}, rd);
    max_iter_q = lim;
    check_limit_reg(lim);
  endtask

  // block idle: nothing queued, nothing driven, nothing outstanding
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_points.size() != 0 || start || predicted_escapes.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] lim, input int n_points, input int idle,
                           input bit fast_escape);
    point_t p;
    wait_idle();
    write_limit(lim);
    idle_pct = idle;
    repeat (n_points) begin
      p = fast_escape ? escape_point() : rand_point();
      pending_points = {pending_points, p};
    end
  endtask

  // item driver: predict on accept, then offer the next queued point
  always @(posedge clk) begin : drive_points
    point_t nxt;
    escape_t pred;
    logic taken;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        pred = predict_escape(in_c_real, in_c_imag, max_iter_q);
        predicted_escapes = {predicted_escapes, pred};
      end
      if (!start || taken) begin
        if (pending_points.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
            !(pending_points[0].drain && predicted_escapes.size() != 0)) begin
          nxt = pending_points.pop_front();
          in_c_real <= nxt.re;
          in_c_imag <= nxt.im;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : check_results
    escape_t want;
    if (rst_n && out_valid) begin
      if (predicted_escapes.size() == 0) begin
        report_mismatch($sformatf("result with none pending, count %0d",
                                  out_iteration_count));
      end else begin
        want = predicted_escapes.pop_front();
        if (out_iteration_count !== want.count) begin
          report_mismatch($sformatf("c=(%h,%h) count %0d, want %0d", want.re, want.im,
                                    out_iteration_count, want.count));
        end
        if (out_reached_limit !== want.at_limit) begin
          report_mismatch($sformatf("c=(%h,%h) limit flag %b, want %b", want.re, want.im,
                                    out_reached_limit, want.at_limit));
        end
      end
    end
  end

  // watchdog on cycles with no item in or out
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_limit_reg(mbe_pkg::MAX_ITER_RESET);

    // directed points at the reset limit: field extremes, edges at 2.0, known orbits
    idle_pct = 0;
    push_point(32'h0000_0000, 32'h0000_0000, 1'b0);
    push_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    push_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    push_point(32'h2000_0000, 32'h0000_0000, 1'b0);
    push_point(32'h1FFF_FFFF, 32'h0000_0000, 1'b0);
    push_point(32'hE000_0000, 32'h0000_0000, 1'b0);
    push_point(32'h0000_0000, 32'h2000_0000, 1'b0);
    push_point(32'h0400_0000, 32'h0000_0000, 1'b0);
    push_point(32'hF400_0000, 32'h0000_0000, 1'b0);
    push_point(32'hF000_0000, 32'h0000_0000, 1'b0);
    push_point(32'h0000_0000, 32'h1000_0000, 1'b0);
    push_point(32'h0000_0000, 32'hF000_0000, 1'b1);
    push_point(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    push_point(32'h1000_0000, 32'h0000_0000, 1'b0);
    push_point(32'hF400_0000, 32'h0199_999A, 1'b0);
    push_point(32'h04CC_CCCD, 32'h0800_0000, 1'b0);
    push_point(32'hE800_0000, 32'h0000_0000, 1'b0);
    push_point(32'h0800_0000, 32'h0800_0000, 1'b0);
    push_point(32'h1000_0000, 32'h1000_0000, 1'b0);

    // random phases over several limits, extremes included
    run_phase(16'd1, 100, 0, 1'b0);
    run_phase(16'd0, 40, 86, 1'b0);
    run_phase(16'hFFFF, 15, 7, 1'b1);
    push_point(32'h0000_0000, 32'h0000_0000, 1'b0);
    push_point(32'hE000_0000, 32'h0000_0000, 1'b0);
    run_phase(16'd32, 400, 0, 1'b0);
    run_phase(16'd100, 300, 86, 1'b0);
    run_phase(16'($urandom_range(2, 64)), 300, 7, 1'b0);
    run_phase(16'd255, 250, 0, 1'b0);
    run_phase(16'($urandom_range(1, 16)), 200, 86, 1'b0);

    // drain and let any stray result show up
    do @(negedge clk);
    while (pending_points.size() != 0 || start || predicted_escapes.size() != 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mbe_pkg.sv
hw/rtl/mbe_mul.sv
hw/rtl/mandelbrot_escape_time_core.sv
sim/mandelbrot_escape_time_core_tb.sv
